/* rtl/r2fft_pkg.sv */
// ----------------------------------------------------------------------------
// r2fft_pkg: shared types, constants and functions
// Payload structs, controller states and twiddle ROM for the radix-2 FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned DataW     = 24;

  localparam logic [0:0] RegInverse = 1'b0;
  localparam logic [0:0] RegLog2    = 1'b1;

  typedef struct packed {
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
  } in_beat_t;

  typedef struct packed {
    logic signed [23:0] result_re;
    logic signed [23:0] result_im;
    logic [5:0]         bin_index;
    logic               frame_last;
  } out_beat_t;

  typedef enum logic [2:0] {
    StLoad,
    StPermRd,
    StPermWr,
    StBflyRdA,
    StBflyRdB,
    StBflyWr,
    StOutRd,
    StOut
  } state_e;

  // cos(2*pi*t/64), t = 0..16
  function automatic logic signed [16:0] cos_rom(input logic [4:0] t);
    logic signed [16:0] v;
    case (t)
      5'd0:  v = 17'sd32767;
      5'd1:  v = 17'sd32610;
      5'd2:  v = 17'sd32138;
      5'd3:  v = 17'sd31357;
      5'd4:  v = 17'sd30273;
      5'd5:  v = 17'sd28898;
      5'd6:  v = 17'sd27245;
      5'd7:  v = 17'sd25330;
      5'd8:  v = 17'sd23170;
      5'd9:  v = 17'sd20788;
      5'd10: v = 17'sd18205;
      5'd11: v = 17'sd15447;
      5'd12: v = 17'sd12540;
      5'd13: v = 17'sd9512;
      5'd14: v = 17'sd6393;
      5'd15: v = 17'sd3212;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > 26'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -26'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

/* rtl/r2fft_mem.sv */
// ----------------------------------------------------------------------------
// r2fft_mem: sample store
// Single write, single read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module r2fft_mem #(
  parameter int unsigned Depth = r2fft_pkg::MaxPoints,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [47:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [47:0]      rdata_o
);

  logic [47:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/r2fft_bfly.sv */
// ----------------------------------------------------------------------------
// r2fft_bfly: butterfly datapath
// Twiddle lookup, complex multiply with rounding, add/subtract with saturation.
// Products are registered after the multiply.
// ----------------------------------------------------------------------------
module r2fft_bfly (
  input  logic               clk_i,
  input  logic [4:0]         tw_idx_i,
  input  logic               inverse_i,
  input  logic signed [23:0] b_re_i,
  input  logic signed [23:0] b_im_i,
  input  logic               mul_en_i,
  input  logic signed [23:0] a_re_i,
  input  logic signed [23:0] a_im_i,
  output logic [47:0]        sum_o,
  output logic [47:0]        dif_o
);

  logic signed [16:0] wc, ws;
  logic signed [41:0] pr_d, pi_d, pr_q, pi_q;
  logic signed [26:0] qr_s, qi_s;
  logic signed [23:0] qr, qi;

  always_comb begin
    if (tw_idx_i <= 5'd16) begin
      wc = r2fft_pkg::cos_rom(tw_idx_i);
      ws = r2fft_pkg::cos_rom(5'd16 - tw_idx_i);
    end else begin
      wc = -r2fft_pkg::cos_rom(5'(6'd32 - {1'b0, tw_idx_i}));
      ws = r2fft_pkg::cos_rom(tw_idx_i - 5'd16);
    end
    if (!inverse_i) begin
      ws = -ws;
    end
    pr_d = 42'(b_re_i * wc) - 42'(b_im_i * ws);
    pi_d = 42'(b_re_i * ws) + 42'(b_im_i * wc);
  end

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      pr_q <= pr_d;
      pi_q <= pi_d;
    end
  end

  always_comb begin
    logic signed [41:0] rr, ri;
    rr = (pr_q + 42'sd16384) >>> 15;
    ri = (pi_q + 42'sd16384) >>> 15;
    if (rr > 42'sd8388607) qr = 24'sh7fffff;
    else if (rr < -42'sd8388608) qr = 24'sh800000;
    else qr = rr[23:0];
    if (ri > 42'sd8388607) qi = 24'sh7fffff;
    else if (ri < -42'sd8388608) qi = 24'sh800000;
    else qi = ri[23:0];
    qr_s = 27'(qr);
    qi_s = 27'(qi);
    sum_o = {r2fft_pkg::sat24(26'(27'(a_re_i) + qr_s)),
             r2fft_pkg::sat24(26'(27'(a_im_i) + qi_s))};
    dif_o = {r2fft_pkg::sat24(26'(27'(a_re_i) - qr_s)),
             r2fft_pkg::sat24(26'(27'(a_im_i) - qi_s))};
  end

endmodule

/* rtl/radix2_fft_forward_inverse_top.sv */
// ----------------------------------------------------------------------------
// radix2_fft_forward_inverse_top: in-place radix-2 DIT FFT/IFFT
// Order: after the last sample of a frame come the permutation (S swapped
//   pairs, 28 for N = 64), the log2N butterfly stages and an output read;
//   the N results then follow back to back.
// Throughput: one sample per cycle while loading; a frame is loaded,
//   transformed and output in turn through the single store port.
// Reset clears control state and registers (inverse off, log2 6); no store
//   clearing. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module radix2_fft_forward_inverse_top #(
  parameter int unsigned MaxPoints = r2fft_pkg::MaxPoints
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  r2fft_pkg::in_beat_t  in_i,
  output logic                 strobe_o,
  output r2fft_pkg::out_beat_t out_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [2:0]           cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MaxPoints);
  // Log2 of the largest power of two that fits within MaxPoints.
  localparam logic [2:0] MaxLog = 3'($clog2(MaxPoints + 1) - 1);

  r2fft_pkg::state_e state_q, state_d;
  logic       inverse_q;
  logic [2:0] log2_q, lg_q, lg_d, lg_now;
  logic [6:0] cnt_q, cnt_d;       // load count / permutation / output index; butterfly write phase
  logic [2:0] st_q, st_d;         // butterfly stage
  logic [5:0] k_q, k_d;           // butterfly index within stage; permutation step
  logic [47:0] a_q, a_d;
  logic       we;
  logic [AddrW-1:0] waddr, raddr;
  logic [47:0] wdata, rdata, sum, dif;
  logic [5:0] rev, ia, ib, half;
  logic [4:0] tw;
  logic [6:0] n_now, n_lg;

  // Clamp length to the legal range.
  always_comb begin
    lg_now = log2_q;
    if (lg_now == 3'd0) lg_now = 3'd1;
    if (lg_now > MaxLog) lg_now = MaxLog;
    n_now = 7'd1 << lg_now;
    n_lg  = 7'd1 << lg_q;
  end

  // Bit-reverse of cnt over lg_q bits.
  always_comb begin
    rev = '0;
    for (int i = 0; i < 6; i++) begin
      if (i < int'(lg_q)) rev[int'(lg_q) - 1 - i] = cnt_q[i];
    end
  end

  // Butterfly addresses: k splits into group and offset at the stage bit.
  always_comb begin
    logic [5:0] lowm;
    half = 6'd1 << st_q;
    lowm = half - 6'd1;
    ia   = ((k_q & ~lowm) << 1) | (k_q & lowm);
    ib   = ia | half;
    tw   = 5'((k_q & lowm) << (3'd5 - st_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inverse_q <= 1'b0;
      log2_q    <= 3'd6;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == r2fft_pkg::RegInverse) inverse_q <= cfg_data_i[0];
      else log2_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= r2fft_pkg::StLoad;
      cnt_q   <= '0;
      st_q    <= '0;
      k_q     <= '0;
      lg_q    <= 3'd1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      st_q    <= st_d;
      k_q     <= k_d;
      lg_q    <= lg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
  end

  always_comb begin
    logic signed [24:0] rr, ri;
    logic signed [24:0] rnd;
    state_d  = state_q;
    cnt_d    = cnt_q;
    st_d     = st_q;
    k_d      = k_q;
    lg_d     = lg_q;
    a_d      = a_q;
    we       = 1'b0;
    waddr    = cnt_q[AddrW-1:0];
    wdata    = {{8{in_i.sample_re[15]}}, in_i.sample_re,
                {8{in_i.sample_im[15]}}, in_i.sample_im};
    raddr    = cnt_q[AddrW-1:0];
    busy     = 1'b1;
    strobe_o = 1'b0;
    rnd      = 25'sd1 <<< (lg_q - 3'd1);
    rr       = (25'(signed'(rdata[47:24])) + rnd) >>> lg_q;
    ri       = (25'(signed'(rdata[23:0])) + rnd) >>> lg_q;
    out_o.result_re  = inverse_q ? rr[23:0] : rdata[47:24];
    out_o.result_im  = inverse_q ? ri[23:0] : rdata[23:0];
    out_o.bin_index  = cnt_q[5:0];
    out_o.frame_last = (cnt_q == n_lg - 7'd1);
    case (state_q)
      r2fft_pkg::StLoad: begin
        busy = 1'b0;
        if (start) begin
          we    = 1'b1;
          cnt_d = cnt_q + 7'd1;
          if (cnt_q + 7'd1 >= n_now) begin
            lg_d    = lg_now;
            cnt_d   = '0;
            state_d = r2fft_pkg::StPermRd;
          end
        end
      end
      // Swap pairs i<rev(i): read i, hold it; read rev; write both.
      r2fft_pkg::StPermRd: begin
        raddr = cnt_q[AddrW-1:0];
        if ({1'b0, rev} > cnt_q) begin
          state_d = r2fft_pkg::StPermWr;
        end else if (cnt_q + 7'd1 == n_lg) begin
          cnt_d = '0; st_d = '0; k_d = '0;
          state_d = r2fft_pkg::StBflyRdA;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      r2fft_pkg::StPermWr: begin
        // k = 0: rdata = mem[i], held in a; k = 1: rdata = mem[rev]
        raddr = rev[AddrW-1:0];
        if (k_q == 6'd0) begin
          a_d = rdata;
          k_d = 6'd1;
        end else begin
          we    = 1'b1;
          waddr = cnt_q[AddrW-1:0];
          wdata = rdata;
          k_d   = 6'd2;
          if (k_q == 6'd2) begin
            // i < rev(i) <= N-1, so the next index is still in the frame.
            waddr = rev[AddrW-1:0];
            wdata = a_q;
            k_d   = 6'd0;
            cnt_d = cnt_q + 7'd1;
            state_d = r2fft_pkg::StPermRd;
          end
        end
      end
      r2fft_pkg::StBflyRdA: begin
        raddr   = ib[AddrW-1:0];
        state_d = r2fft_pkg::StBflyRdB;
      end
      r2fft_pkg::StBflyRdB: begin
        raddr   = ia[AddrW-1:0];
        state_d = r2fft_pkg::StBflyWr;
      end
      r2fft_pkg::StBflyWr: begin
        if (k_q[0] == 1'b0 && cnt_q[0] == 1'b0) begin
          a_d   = rdata;
          cnt_d = 7'd1;
          we    = 1'b1;
          waddr = ia[AddrW-1:0];
          wdata = sum;
        end else begin
          cnt_d = '0;
          we    = 1'b1;
          waddr = ia[AddrW-1:0];
          wdata = sum;
        end
        a_d   = rdata;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[0]) begin
          waddr = ib[AddrW-1:0];
          wdata = dif;
          cnt_d = '0;
          if (7'(k_q) + 7'd1 == (n_lg >> 1)) begin
            k_d = '0;
            if (st_q + 3'd1 == lg_q) begin
              state_d = r2fft_pkg::StOutRd;
            end else begin
              st_d = st_q + 3'd1;
              state_d = r2fft_pkg::StBflyRdA;
            end
          end else begin
            k_d = k_q + 6'd1;
            state_d = r2fft_pkg::StBflyRdA;
          end
        end
      end
      r2fft_pkg::StOutRd: begin
        raddr   = '0;
        state_d = r2fft_pkg::StOut;
      end
      r2fft_pkg::StOut: begin
        strobe_o = 1'b1;
        raddr    = AddrW'(cnt_q + 7'd1);
        cnt_d    = cnt_q + 7'd1;
        if (cnt_q + 7'd1 == n_lg) begin
          cnt_d   = '0;
          state_d = r2fft_pkg::StLoad;
        end
      end
      default: state_d = r2fft_pkg::StLoad;
    endcase
  end

  r2fft_mem #(.Depth(MaxPoints), .AddrW(AddrW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Multiply in RdB (b arrives), add in Wr using a read back into rdata.
  r2fft_bfly u_bfly (
    .clk_i     (clk_i),
    .tw_idx_i  (tw),
    .inverse_i (inverse_q),
    .b_re_i    (signed'(rdata[47:24])),
    .b_im_i    (signed'(rdata[23:0])),
    .mul_en_i  (state_q == r2fft_pkg::StBflyRdB),
    .a_re_i    (signed'(cnt_q[0] ? a_q[47:24] : rdata[47:24])),
    .a_im_i    (signed'(cnt_q[0] ? a_q[23:0] : rdata[23:0])),
    .sum_o     (sum),
    .dif_o     (dif)
  );

endmodule

/* rtl/r2fft_checker.sv */
// ----------------------------------------------------------------------------
// r2fft_checker: port-level checks
// Watches handshake and result framing on the top-level ports.
// ----------------------------------------------------------------------------
module r2fft_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 busy,
  input logic                 strobe_o,
  input r2fft_pkg::out_beat_t out_o
);

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy) else $error("result beat while idle");

  a_bin_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !out_o.frame_last |=> strobe_o &&
      out_o.bin_index == $past(out_o.bin_index) + 6'd1)
    else $error("bin sequence broken");

  a_first_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(strobe_o) |-> out_o.bin_index == 6'd0)
    else $error("frame does not start at bin 0");

  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && out_o.frame_last |=> !strobe_o)
    else $error("beat after last bin");

endmodule

bind radix2_fft_forward_inverse_top r2fft_checker u_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .busy     (busy),
  .strobe_o (strobe_o),
  .out_o    (out_o)
);

/* sim/radix2_fft_forward_inverse_top_tb.sv */
// ----------------------------------------------------------------------------
// radix2_fft_forward_inverse_top_tb: self-checking bench for the radix-2 FFT
// Streams sample frames through the block under several lengths and both
// directions, predicts every bin with an independent integer FFT model and
// compares each result beat in order.
// ----------------------------------------------------------------------------
module radix2_fft_forward_inverse_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [23:0] re;
    logic signed [23:0] im;
  } cplx_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  r2fft_pkg::in_beat_t  in_i = '0;
  logic                 strobe_o;
  r2fft_pkg::out_beat_t out_o;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_idx_i = 1'b0;
  logic [2:0]           cfg_data_i = '0;

  radix2_fft_forward_inverse_top DUT (
    .clk_i, .rst_ni, .start, .busy, .in_i, .strobe_o, .out_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: its own copy of the registers and the sample store.
  logic                 pred_inverse = 1'b0;
  logic [2:0]           pred_log2 = 3'd6;
  cplx_t                frame_buf[64];
  int unsigned          frame_fill = 0;
  r2fft_pkg::out_beat_t bins_due[$];
  int                   errors = 0;
  int                   send_gap_pct = 0;

  localparam int unsigned SlowestFrame = 3 * 32 + 3 * 32 * 6 + 64 + 16;

  function automatic logic signed [23:0] clip24(input longint v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // Quarter-wave cosine of 2*pi*t/64, t = 0..16.
  function automatic int quarter_cos(input int t);
    int tab[17] = '{32767, 32610, 32138, 31357, 30273, 28898, 27245, 25330,
                    23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
    return tab[t];
  endfunction

  function automatic int unsigned eff_log2();
    if (pred_log2 < 3'd1) return 1;
    if (pred_log2 > 3'd6) return 6;
    return pred_log2;
  endfunction

  // Run the transform over the stored frame and queue its bins.
  task automatic compute_spectrum(input int unsigned lg);
    int unsigned pts, j, hlf, stride, t;
    int wc, ws;
    longint pr, pi_, rnd;
    cplx_t tmp, qa, qb;
    r2fft_pkg::out_beat_t bin;
    pts = 1 << lg;
    for (int unsigned i = 0; i < pts; i++) begin
      j = 0;
      for (int unsigned b = 0; b < lg; b++) j |= ((i >> b) & 1) << (lg - 1 - b);
      if (i < j) begin
        tmp = frame_buf[i]; frame_buf[i] = frame_buf[j]; frame_buf[j] = tmp;
      end
    end
    for (int unsigned st = 0; st < lg; st++) begin
      hlf = 1 << st;
      stride = 32 / hlf;
      for (int unsigned base = 0; base < pts; base += 2 * hlf) begin
        for (int unsigned k = 0; k < hlf; k++) begin
          t = (k * stride) & 31;
          if (t <= 16) begin
            wc = quarter_cos(t); ws = quarter_cos(16 - t);
          end else begin
            wc = -quarter_cos(32 - t); ws = quarter_cos(t - 16);
          end
          if (!pred_inverse) ws = -ws;
          qb = frame_buf[base + k + hlf];
          pr = longint'(qb.re) * wc - longint'(qb.im) * ws;
          pi_ = longint'(qb.re) * ws + longint'(qb.im) * wc;
          qb.re = clip24((pr + 16384) >>> 15);
          qb.im = clip24((pi_ + 16384) >>> 15);
          qa = frame_buf[base + k];
          frame_buf[base + k].re = clip24(longint'(qa.re) + qb.re);
          frame_buf[base + k].im = clip24(longint'(qa.im) + qb.im);
          frame_buf[base + k + hlf].re = clip24(longint'(qa.re) - qb.re);
          frame_buf[base + k + hlf].im = clip24(longint'(qa.im) - qb.im);
        end
      end
    end
    rnd = longint'(1) << (lg - 1);
    for (int unsigned i = 0; i < pts; i++) begin
      if (pred_inverse) begin
        frame_buf[i].re = clip24((longint'(frame_buf[i].re) + rnd) >>> lg);
        frame_buf[i].im = clip24((longint'(frame_buf[i].im) + rnd) >>> lg);
      end
      bin.result_re = frame_buf[i].re;
      bin.result_im = frame_buf[i].im;
      bin.bin_index = i[5:0];
      bin.frame_last = (i == pts - 1);
      bins_due.push_back(bin);
    end
  endtask

  // Store one sample; the length is read on every beat.
  task automatic load_sample(input r2fft_pkg::in_beat_t s);
    int unsigned lg;
    lg = eff_log2();
    frame_buf[frame_fill & 63].re = 24'(s.sample_re);
    frame_buf[frame_fill & 63].im = 24'(s.sample_im);
    frame_fill = (frame_fill + 1) & 127;
    if (frame_fill >= (1 << lg)) begin
      frame_fill = 0;
      compute_spectrum(lg);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("%t: %s mismatch: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Drop start only for idle cycles; hold the beat until busy is low at an edge.
  task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im);
    r2fft_pkg::in_beat_t s;
    s.sample_re = re;
    s.sample_im = im;
    if ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    start <= 1'b1;
    in_i <= s;
    do @(posedge clk_i); while (busy);
    load_sample(s);
  endtask

  // Drop start, wait for all bins, then let the block settle back to idle.
  task automatic drain();
    start <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Registers are only written with the block idle.
  task automatic write_reg(input logic idx, input logic [2:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == r2fft_pkg::RegInverse) pred_inverse = val[0];
    else pred_log2 = val;
  endtask

  task automatic send_frame_random(input int unsigned pts);
    for (int unsigned i = 0; i < pts; i++) begin
      case ($urandom_range(9))
        0: send_sample(16'sh7fff, 16'sh8000);
        1: send_sample(16'sh8000, 16'sh7fff);
        default: send_sample(16'($urandom), 16'($urandom));
      endcase
    end
  endtask

  // Extremes: full-scale DC and alternating patterns on short frames, too small to saturate the stages.
  task automatic test_directed();
    write_reg(r2fft_pkg::RegInverse, 3'd0);
    write_reg(r2fft_pkg::RegLog2, 3'd1);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh0000);
    write_reg(r2fft_pkg::RegLog2, 3'd3);
    for (int i = 0; i < 8; i++) send_sample(16'sh7fff, 16'sh8000);
    write_reg(r2fft_pkg::RegInverse, 3'd1);
    write_reg(r2fft_pkg::RegLog2, 3'd0);   // zero length acts as two points
    send_sample(16'sh8000, 16'sh0001);
    send_sample(16'sh0001, 16'shffff);
    write_reg(r2fft_pkg::RegLog2, 3'd7);   // beyond the largest acts as 64 points
    drain();
  endtask

  // Full-length frames in both directions.
  task automatic test_long_frames();
    write_reg(r2fft_pkg::RegInverse, 3'd0);
    send_frame_random(64);
    write_reg(r2fft_pkg::RegInverse, 3'd1);
    write_reg(r2fft_pkg::RegLog2, 3'd6);
    send_frame_random(64);
  endtask

  // Shrink the length mid-frame: the stored count already passes the new size.
  task automatic test_length_change();
    write_reg(r2fft_pkg::RegLog2, 3'd3);
    for (int i = 0; i < 5; i++) send_sample(16'($urandom), 16'($urandom));
    write_reg(r2fft_pkg::RegLog2, 3'd2);
    send_sample(16'($urandom), 16'($urandom));
    write_reg(r2fft_pkg::RegLog2, 3'd3);
    send_frame_random(8);
  endtask

  // Random frames mostly short, through the idle phases.
  task automatic test_random(input int unsigned beats);
    int unsigned sent;
    sent = 0;
    while (sent < beats) begin
      write_reg(r2fft_pkg::RegInverse, 3'($urandom_range(1)));
      write_reg(r2fft_pkg::RegLog2, 3'($urandom_range(1, 4)));
      send_frame_random(1 << eff_log2());
      sent += 1 << eff_log2();
    end
  endtask

  // Compare every strobed beat against the oldest predicted bin.
  always @(posedge clk_i) begin
    r2fft_pkg::out_beat_t want;
    if (rst_ni && strobe_o) begin
      if (bins_due.size() == 0) begin
        report_mismatch("unexpected bin", out_o.bin_index, -1);
      end else begin
        want = bins_due.pop_front();
        if (out_o.result_re !== want.result_re)
          report_mismatch("result_re", out_o.result_re, want.result_re);
        if (out_o.result_im !== want.result_im)
          report_mismatch("result_im", out_o.result_im, want.result_im);
        if (out_o.bin_index !== want.bin_index)
          report_mismatch("bin_index", out_o.bin_index, want.bin_index);
        if (out_o.frame_last !== want.frame_last)
          report_mismatch("frame_last", out_o.frame_last, want.frame_last);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_long_frames();
    test_length_change();
    send_gap_pct = 75;
    test_random(8);
    send_gap_pct = 21;
    test_random(8);
    send_gap_pct = 0;
    test_random(8);
    drain();
    repeat (SlowestFrame) @(posedge clk_i);
    if (bins_due.size() != 0) errors++;
    if (errors == 0) begin
      $display("radix2_fft_forward_inverse_top_tb passed");
    end else begin
      $display("radix2_fft_forward_inverse_top_tb failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("radix2_fft_forward_inverse_top_tb failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/r2fft_pkg.sv
rtl/r2fft_mem.sv
rtl/r2fft_bfly.sv
rtl/radix2_fft_forward_inverse_top.sv
rtl/r2fft_checker.sv
sim/radix2_fft_forward_inverse_top_tb.sv
